// ===== hdl/wsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_pkg: shared types and constants
// Widths, register codes and structs for the windowed substring locator.
// ----------------------------------------------------------------------------
package wsl_pkg;

  localparam int PAT_MAX = 16;
  localparam longint unsigned ARRAY_DEPTH = 64'd65536;

  localparam int DATA_W    = 8;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 5;
  localparam int START_W   = 16;
  localparam int END_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [END_W-1:0] LIMIT_RESET = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_START_POSITION = 3'd3,
    REG_SEARCH_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             found;
    logic [END_W-1:0] end_index;
  } result_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/wsl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_if: stream channels
// Byte request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsl_in_if;
  logic                       valid;
  logic                       ready;
  logic [wsl_pkg::DATA_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [wsl_pkg::END_W-1:0] end_index;

  modport source (output valid, output found, output end_index, input ready);
  modport sink   (input valid, input found, input end_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/wsl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_cell: one pattern position
// Flags that pattern bytes 0..i match the bytes ending at the current one,
// and hands the flag to the next cell for the following byte.
// ----------------------------------------------------------------------------
module wsl_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire wsl_pkg::cell_ctrl_t   ctrl,
  input  wire [wsl_pkg::DATA_W-1:0]  data_byte,
  input  wire [wsl_pkg::DATA_W-1:0]  pat_byte,
  input  wire                        chain_in,
  output logic                       hit,
  output logic                       chain_out
);

  logic flag;

  assign hit       = chain_in && (data_byte == pat_byte);
  assign chain_out = flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.clear) begin
      flag <= 1'b0;
    end else if (ctrl.advance) begin
      flag <= hit;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wsl_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_outq: two-entry result queue
// Holds results while the sink stalls so requests keep flowing.
// ----------------------------------------------------------------------------
module wsl_outq (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire wsl_pkg::result_t push_data,
  input  wire                  pop,
  output logic                 full,
  output logic                 head_valid,
  output wsl_pkg::result_t     head
);

  wsl_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count[1];
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/windowed_substring_locate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_substring_locate: streaming first-match substring search
// Bytes arrive one per request; the run ends at the byte flagged last_byte.
// ----------------------------------------------------------------------------
// Takes one byte every cycle: a row of PAT_MAX cells, one per pattern byte,
// compares the byte against all pattern positions at once and passes
// partial-match flags down the row. At most one result is produced per run
// (found, or not-found at the last byte) and lands in a two-entry output
// queue; requests stall only while that queue is full.
// Configure only while idle.
// ----------------------------------------------------------------------------
module windowed_substring_locate #(
  parameter int              PAT_MAX     = wsl_pkg::PAT_MAX,
  parameter longint unsigned ARRAY_DEPTH = wsl_pkg::ARRAY_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst,
  wsl_in_if.sink                        in_ch,
  wsl_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire [wsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [wsl_pkg::WORD_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(ARRAY_DEPTH + 64'd1);
  localparam int CMP_W = ((POS_W > wsl_pkg::END_W) ? POS_W : wsl_pkg::END_W) + 1;
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(ARRAY_DEPTH);

  logic [wsl_pkg::WORD_W-1:0]  pattern_low;
  logic [wsl_pkg::WORD_W-1:0]  pattern_high;
  logic [wsl_pkg::LEN_W-1:0]   pattern_length;
  logic [wsl_pkg::START_W-1:0] start_position;
  logic [wsl_pkg::END_W-1:0]   search_limit;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic             answered;
  logic             answered_next;

  logic [2*wsl_pkg::WORD_W-1:0] pattern;
  logic [PAT_MAX-1:0]           hit;
  logic [PAT_MAX-1:0]           chain;
  logic [PAT_MAX-1:0]           len_sel;
  wsl_pkg::cell_ctrl_t          cell_ctrl;

  logic             in_fire;
  logic             out_fire;
  logic             q_full;
  logic             q_valid;
  wsl_pkg::result_t q_head;
  logic             res_valid;
  wsl_pkg::result_t res;

  logic [CMP_W-1:0] end_pos;
  logic [CMP_W-1:0] min_end;
  logic             pos_room;
  logic             window_hit;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      start_position <= '0;
      search_limit   <= wsl_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (wsl_pkg::cfg_reg_t'(cfg_index))
        wsl_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        wsl_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        wsl_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wsl_pkg::LEN_W-1:0];
        wsl_pkg::REG_START_POSITION: start_position <= cfg_data[wsl_pkg::START_W-1:0];
        wsl_pkg::REG_SEARCH_LIMIT:   search_limit   <= cfg_data[wsl_pkg::END_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern  = {pattern_high, pattern_low};
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign cell_ctrl.advance = in_fire;
  assign cell_ctrl.clear   = in_fire && in_ch.last_byte;

  // cell row
  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    logic chain_in;
    if (i == 0) begin : g_head
      assign chain_in = 1'b1;
    end else begin : g_link
      assign chain_in = chain[i-1];
    end
    wsl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .data_byte (in_ch.data_byte),
      .pat_byte  (pattern[8*i +: 8]),
      .chain_in  (chain_in),
      .hit       (hit[i]),
      .chain_out (chain[i])
    );
    assign len_sel[i] = (pattern_length == wsl_pkg::LEN_W'(i + 1));
  end

  // lengths above PAT_MAX select no cell and never match
  assign window_hit = |(hit & len_sel);

  assign pos_room = (byte_position != DEPTH_POS);
  assign end_pos  = CMP_W'(byte_position) + CMP_W'(1);
  assign min_end  = CMP_W'(start_position) + CMP_W'(pattern_length);

  always_comb begin
    res_valid     = 1'b0;
    res.found     = 1'b0;
    res.end_index = '0;
    if (!answered) begin
      if (pattern_length == '0) begin
        res_valid     = 1'b1;
        res.found     = 1'b1;
        res.end_index = wsl_pkg::END_W'(start_position);
      end else if (search_limit == '0) begin
        res_valid = 1'b1;
      end else if (pos_room && (end_pos >= min_end) &&
                   (end_pos <= CMP_W'(search_limit)) && window_hit) begin
        res_valid     = 1'b1;
        res.found     = 1'b1;
        res.end_index = end_pos[wsl_pkg::END_W-1:0];
      end
    end
    if (in_ch.last_byte && !answered && !res_valid) begin
      res_valid = 1'b1;
    end
  end

  always_comb begin
    answered_next      = answered;
    byte_position_next = byte_position;
    if (in_fire) begin
      if (in_ch.last_byte) begin
        answered_next      = 1'b0;
        byte_position_next = '0;
      end else begin
        answered_next = answered || res_valid;
        if (pos_room) begin
          byte_position_next = byte_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answered      <= 1'b0;
      byte_position <= '0;
    end else begin
      answered      <= answered_next;
      byte_position <= byte_position_next;
    end
  end

  wsl_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire && res_valid),
    .push_data  (res),
    .pop        (out_fire),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  assign in_ch.ready      = !q_full;
  assign out_ch.valid     = q_valid;
  assign out_ch.found     = q_head.found;
  assign out_ch.end_index = q_head.end_index;

endmodule

`default_nettype wire

// ===== hdl/wsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsl_checker: port-level checks
// Watches the request and result channels of the substring locator.
// ----------------------------------------------------------------------------
module wsl_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire                       found,
  input wire [wsl_pkg::END_W-1:0]  end_index
);

  // requests not yet answered, saturating; each request yields at most one result
  logic [3:0] credit;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({in_fire, out_fire})
        2'b10:   credit <= (credit == 4'hF) ? credit : credit + 4'd1;
        2'b01:   credit <= credit - 4'd1;
        default: credit <= credit;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_nil_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (end_index == '0))
    else $error("not-found result with nonzero end_index");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (credit != 4'd0))
    else $error("result without a prior request");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(end_index)))
    else $error("stalled result changed");

endmodule

bind windowed_substring_locate wsl_checker u_wsl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .found     (out_ch.found),
  .end_index (out_ch.end_index)
);

`default_nettype wire

// ===== bench/wsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsl_scoreboard: result predictor and scoreboard for the substring locator
// Watches the byte and result channels and the register port, keeps its own
// search state, and compares each result with the oldest predicted answer.
// ----------------------------------------------------------------------------
module wsl_scoreboard
  import wsl_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  wire [DATA_W-1:0]    in_data,
  input  wire                 in_last,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  wire                 out_found,
  input  wire [END_W-1:0]     out_end,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [WORD_W-1:0]    cfg_data,
  output int                  errors,
  output int                  pending
);

  logic [WORD_W-1:0]  pat_lo, pat_hi;
  logic [LEN_W-1:0]   pat_len;
  logic [START_W-1:0] first_start;
  logic [END_W-1:0]   end_limit;

  logic [END_W-1:0]   run_pos;
  logic [DATA_W-1:0]  history [PAT_MAX-1];
  logic               answered;

  result_t answers_due[$];
  int      mismatches = 0;

  assign errors = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DATA_W-1:0] pattern_byte(input int k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic window_hit(input logic [DATA_W-1:0] cur);
    logic [DATA_W-1:0] b;
    for (int k = 0; k < PAT_MAX; k++) begin
      if (k < int'(pat_len)) begin
        if (k == 0) begin
          b = cur;
        end else begin
          b = history[k-1];
        end
        if (b != pattern_byte(int'(pat_len) - 1 - k)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic result_t make_answer(input logic hit, input int idx);
    result_t r;
    r.found     = hit;
    r.end_index = END_W'(idx);
    return r;
  endfunction

  task automatic clear_run();
    run_pos  = '0;
    answered = 1'b0;
    foreach (history[k]) history[k] = '0;
  endtask

  task automatic locate_step(input logic [DATA_W-1:0] data, input logic last);
    int stop;
    if (!answered) begin
      if (pat_len == 0) begin
        answers_due.push_back(make_answer(1'b1, int'(first_start)));
        answered = 1'b1;
      end else if (end_limit == 0) begin
        answers_due.push_back(make_answer(1'b0, 0));
        answered = 1'b1;
      end else if (pat_len <= PAT_MAX && run_pos < ARRAY_DEPTH) begin
        stop = int'(run_pos) + 1;
        if (stop >= int'(first_start) + int'(pat_len) && stop <= int'(end_limit) &&
            window_hit(data)) begin
          answers_due.push_back(make_answer(1'b1, stop));
          answered = 1'b1;
        end
      end
    end
    for (int k = PAT_MAX - 2; k >= 1; k--) history[k] = history[k-1];
    history[0] = data;
    if (run_pos < ARRAY_DEPTH) run_pos = run_pos + 1'b1;
    if (last) begin
      if (!answered) answers_due.push_back(make_answer(1'b0, 0));
      clear_run();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pat_lo      = '0;
      pat_hi      = '0;
      pat_len     = '0;
      first_start = '0;
      end_limit   = LIMIT_RESET;
      clear_run();
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with none pending, end_index", int'(out_end), 0);
        end else begin
          want = answers_due.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", int'(out_found), int'(want.found));
          if (out_end !== want.end_index)
            report_mismatch("end_index", int'(out_end), int'(want.end_index));
        end
      end
      if (in_valid && in_ready) locate_step(in_data, in_last);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LOW:    pat_lo      = cfg_data;
          REG_PATTERN_HIGH:   pat_hi      = cfg_data;
          REG_PATTERN_LENGTH: pat_len     = cfg_data[LEN_W-1:0];
          REG_START_POSITION: first_start = cfg_data[START_W-1:0];
          REG_SEARCH_LIMIT:   end_limit   = cfg_data[END_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= answers_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for windowed_substring_locate
// Streams byte runs through the locator under several search settings:
// directed corner runs, random runs with embedded and corrupted pattern
// copies, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import wsl_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsl_in_if  in_ch ();
  wsl_out_if out_ch ();

  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [WORD_W-1:0] cfg_data;

  int errors;
  int pending;
  int quiet = 0;

  byte_req_t         req_q[$];
  logic [DATA_W-1:0] run_buf[$];
  logic [127:0]      pat_bytes;
  int                pat_len;
  logic              steady;
  logic              hold_off;
  event              hold_start;

  always #2 clk = ~clk;

  windowed_substring_locate dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wsl_scoreboard checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data_byte),
    .in_last   (in_ch.last_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_found (out_ch.found),
    .out_end   (out_ch.end_index),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PATTERN_LOW;
    cfg_data        = '0;
    steady          = 1'b0;
    hold_off        = 1'b0;
  end

  // byte sender: holds a request until taken
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(req_q.pop_front());
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (req_q.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= req_q[0].data;
          in_ch.last_byte <= req_q[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && (steady || $urandom_range(99) >= 37);
    end
  end

  initial begin
    forever begin
      @(hold_start);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_search(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                            input int len, input int start, input int limit);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, WORD_W'(len));
    write_reg(REG_START_POSITION, WORD_W'(start));
    write_reg(REG_SEARCH_LIMIT, WORD_W'(limit));
    cfg_we    <= 1'b0;
    pat_bytes = {hi, lo};
    pat_len   = len;
  endtask

  task automatic queue_run();
    byte_req_t r;
    foreach (run_buf[i]) begin
      r.data = run_buf[i];
      r.last = (i == run_buf.size() - 1);
      req_q.push_back(r);
    end
    run_buf.delete();
  endtask

  // waits for the sender to drain, then for every answer, then for the pipe
  task automatic settle();
    do @(posedge clk); while (req_q.size() != 0 || in_ch.valid);
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // random run: noise mixed with pattern bytes, mostly one full pattern copy
  task automatic build_run(output int n);
    int off;
    int pick;
    n = $urandom_range(1, 40);
    for (int k = 0; k < n; k++) begin
      if (pat_len != 0 && $urandom_range(1) == 1) begin
        pick = $urandom_range(pat_len - 1);
        run_buf.push_back(pat_bytes[8*pick +: 8]);
      end else begin
        run_buf.push_back(DATA_W'($urandom_range(255)));
      end
    end
    if (pat_len != 0 && pat_len <= n && $urandom_range(9) < 7) begin
      off = $urandom_range(n - pat_len);
      for (int k = 0; k < pat_len; k++) run_buf[off+k] = pat_bytes[8*k +: 8];
      if ($urandom_range(4) == 0) begin
        pick = off + $urandom_range(pat_len - 1);
        run_buf[pick] = run_buf[pick] ^ DATA_W'($urandom_range(1, 255));
      end
    end
    queue_run();
  endtask

  initial begin
    int n;
    int queued;
    int len, start, limit, r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty pattern answers start position on the first byte
    pat_bytes = '0;
    pat_len   = 0;
    run_buf = '{8'h00, 8'hFF};
    queue_run();
    settle();

    // empty pattern beats a zero limit
    set_search('0, '0, 0, 65535, 0);
    run_buf = '{8'h5A};
    queue_run();
    settle();

    // zero limit: not found on the first byte, nothing after
    set_search(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 3, 0, 0);
    run_buf = '{8'h11, 8'h22};
    queue_run();
    settle();

    // full-length pattern found on the last byte of the run
    set_search(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, PAT_MAX, 0, 65536);
    for (int k = 0; k < PAT_MAX; k++) run_buf.push_back(pat_bytes[8*k +: 8]);
    queue_run();
    settle();

    // one match too early, one ending past the limit
    set_search(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 2, 1, 3);
    run_buf = '{8'hEF, 8'hCD, 8'hEF, 8'hCD};
    queue_run();
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      steady = (phase == 5);
      r = $urandom_range(9);
      if (r == 0)      len = 0;
      else if (r == 1) len = PAT_MAX;
      else if (r == 2) len = PAT_MAX - 1;
      else             len = $urandom_range(1, 4);
      if ($urandom_range(7) == 0) start = $urandom_range(65535);
      else                        start = $urandom_range(20);
      r = $urandom_range(9);
      if (r == 0)      limit = 0;
      else if (r < 3)  limit = $urandom_range(1, 40);
      else if (r == 3) limit = $urandom_range(65536);
      else             limit = 65536;
      set_search({$urandom, $urandom}, {$urandom, $urandom}, len, start, limit);
      queued = 0;
      while (queued < 85) begin
        build_run(n);
        queued += n;
      end
      settle();
    end
    steady = 1'b0;

    // receiver holds off while short answered runs keep coming
    set_search({$urandom, $urandom}, {$urandom, $urandom}, 0, $urandom_range(65535), 65536);
    -> hold_start;
    for (int k = 0; k < 12; k++) build_run(n);
    settle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
